@@ src/ttb_pkg.sv @@
`default_nettype none
package ttb_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic               zero_length;
        logic               last;
    } t_out_item;

    // Numerator components: 17-bit UV delta times 33-bit edge, summed twice.
    localparam int VEC_W = 52;
    localparam int MAG_W = 30;
    localparam int SUM_W = 62;

    // Shared unit operations issued by the sequencer.
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } t_unit_ctl;

endpackage
`default_nettype wire

@@ src/ttb_unit.sv @@
`default_nettype none
// Shared iterative unit: restoring square root of a 62-bit sum, one root
// bit per cycle, or a restoring divide of a 45-bit numerator by a 31-bit
// divisor, one quotient bit per cycle.
module ttb_unit
    import ttb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_ctl         i_ctl,
    input  wire logic [SUM_W-1:0]  i_sum,
    input  wire logic [44:0]       i_num,
    input  wire logic [30:0]       i_den,
    output logic                   o_busy,
    output logic [30:0]            o_root,
    output logic [15:0]            o_quot
);
    logic [5:0]        r_cnt;
    logic              r_mode_div;
    logic [SUM_W-1:0]  r_x;
    logic [30:0]       r_rt;
    logic [30:0]       r_rem;
    logic [44:0]       r_num;
    logic [30:0]       r_den;
    logic [15:0]       r_q;

    logic [32:0] n_trial;
    logic [32:0] n_rem_s;
    logic [31:0] n_shift_d;
    logic [32:0] n_sub_d;

    always_comb begin
        n_rem_s   = {r_rem, r_x[SUM_W-1 -: 2]};
        n_trial   = {r_rt, 2'b01};
        n_shift_d = {r_rem, r_num[44]};
        // One extra bit so that a shifted remainder above 2^31 still compares right.
        n_sub_d   = {1'b0, n_shift_d} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start_sqrt) begin
            r_cnt      <= 6'd31;
            r_mode_div <= 1'b0;
            r_x        <= i_sum;
            r_rt       <= '0;
            r_rem      <= '0;
        end else if (i_ctl.start_div) begin
            r_cnt      <= 6'd45;
            r_mode_div <= 1'b1;
            r_num      <= i_num;
            r_den      <= i_den;
            r_rem      <= '0;
            r_q        <= '0;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            if (!r_mode_div) begin
                r_x <= {r_x[SUM_W-3:0], 2'b00};
                if (n_rem_s >= n_trial) begin
                    r_rem <= 31'(n_rem_s - n_trial);
                    r_rt  <= {r_rt[29:0], 1'b1};
                end else begin
                    r_rem <= n_rem_s[30:0];
                    r_rt  <= {r_rt[29:0], 1'b0};
                end
            end else begin
                r_num <= {r_num[43:0], 1'b0};
                if (!n_sub_d[32]) begin
                    r_rem <= n_sub_d[30:0];
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= n_shift_d[30:0];
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
        end
    end

    assign o_busy = (r_cnt != 6'd0) || i_ctl.start_sqrt || i_ctl.start_div;
    assign o_root = r_rt;
    assign o_quot = r_q;
endmodule
`default_nettype wire

@@ src/triangle_tangent_basis.sv @@
`default_nettype none
// Flow: the first two corners of a triangle are stored as they arrive.
// The third corner starts the work for each corner in turn: setup, products, and for
// each vector a root and three divides on the shared unit; a zero vector skips its part.
// The three results leave through an output register, one per corner.
// No new corner is taken until all three results of a triangle are registered for output.
// Reset: synchronous, active low; clears the corner count and control.
module triangle_tangent_basis
    import ttb_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SETUP = 8'b00000010,
        S_PROD  = 8'b00000100,
        S_VEC   = 8'b00001000,
        S_SQRT  = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_NEXT  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_held;
    logic [1:0] r_k;
    logic       r_vsel;       // 0 tangent, 1 bitangent
    logic [1:0] r_comp;
    logic [1:0] r_pstep;
    logic       r_wait;

    logic signed [POS_WIDTH-1:0] r_pos [9];
    logic signed [15:0]          r_uv  [6];

    logic signed [POS_WIDTH:0] r_e1 [3];
    logic signed [POS_WIDTH:0] r_e2 [3];
    logic signed [16:0]        r_d1u, r_d1v, r_d2u, r_d2v;
    logic                      r_flip;
    logic signed [VEC_W-1:0]   r_tv [3];
    logic signed [VEC_W-1:0]   r_bv [3];
    logic [MAG_W-1:0]          r_m [3];
    logic                      r_neg [3];
    logic [SUM_W-1:0]          r_sum;
    logic [30:0]               r_len;
    logic [15:0]               r_q [6];
    logic                      r_zt, r_zb;
    t_out_item                 r_out;
    logic                      r_ovalid;

    t_unit_ctl   n_ctl;
    logic        u_busy;
    logic [30:0] u_root;
    logic [15:0] u_quot;
    logic [44:0] n_num;

    ttb_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_ctl),
        .i_sum   (r_sum),
        .i_num   (n_num),
        .i_den   (r_len),
        .o_busy  (u_busy),
        .o_root  (u_root),
        .o_quot  (u_quot)
    );

    logic [1:0] n_b, n_c;
    always_comb begin
        n_b = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
        n_c = (r_k == 2'd0) ? 2'd2 : r_k - 2'd1;
    end

    // Magnitudes of the selected vector, and the common shift.
    logic signed [VEC_W-1:0] n_v [3];
    logic [VEC_W-1:0]        n_a [3];
    logic [VEC_W-1:0]        n_or;
    logic [VEC_W-1:0]        n_sh [3];
    logic                    n_zero;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v[i] = r_vsel ? r_bv[i] : r_tv[i];
            n_a[i] = n_v[i][VEC_W-1] ? VEC_W'(-n_v[i]) : VEC_W'(n_v[i]);
        end
        n_or   = n_a[0] | n_a[1] | n_a[2];
        n_zero = (n_or == '0);
        for (int i = 0; i < 3; i++) n_sh[i] = n_a[i];
        // Smallest shift so that the largest magnitude drops below 2^30.
        for (int s = VEC_W - MAG_W; s >= 1; s--) begin
            if (n_or[MAG_W + s - 1]) begin
                for (int i = 0; i < 3; i++) n_sh[i] = n_a[i] >> s;
                break;
            end
        end
        n_num = {1'b0, r_m[r_comp], 14'd0} + {15'd0, r_len[30:1]};
    end

    logic [SUM_W-1:0] n_sq;
    assign n_sq = SUM_W'(r_m[r_pstep]) * SUM_W'(r_m[r_pstep]);

    always_comb begin
        n_state = r_state;
        n_ctl   = '0;
        unique case (r_state)
            S_IDLE:  if (i_valid && r_held == 2'd2) n_state = S_SETUP;
            S_SETUP: n_state = S_PROD;
            S_PROD:  n_state = S_VEC;
            S_VEC:   n_state = n_zero ? S_NEXT : S_SQRT;
            S_SQRT: begin
                if (r_pstep == 2'd3 && !r_wait) n_ctl.start_sqrt = 1'b1;
                if (r_wait && !u_busy) n_state = S_DIV;
            end
            S_DIV: begin
                if (!r_wait) n_ctl.start_div = 1'b1;
                if (r_wait && !u_busy && r_comp == 2'd2) n_state = S_NEXT;
            end
            S_NEXT:  n_state = r_vsel ? S_OUT : S_VEC;
            S_OUT: begin
                if (!r_ovalid || !i_stall)
                    n_state = (r_k == 2'd2) ? S_IDLE : S_SETUP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_held <= (r_held == 2'd2) ? 2'd0 : r_held + 2'd1;
                        r_k    <= 2'd0;
                    end
                end
                S_VEC: begin
                    r_pstep <= 2'd0;
                    r_wait  <= 1'b0;
                    r_sum   <= '0;
                end
                S_SQRT: begin
                    if (r_pstep != 2'd3) begin
                        r_sum   <= r_sum + n_sq;
                        r_pstep <= r_pstep + 2'd1;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (!u_busy) begin
                        r_len  <= u_root;
                        r_wait <= 1'b0;
                        r_comp <= 2'd0;
                    end
                end
                S_DIV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (!u_busy) begin
                        r_wait <= 1'b0;
                        r_comp <= r_comp + 2'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_k <= r_k + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_pos[4'(r_held) * 4'd3 + 4'd0] <= i_data.pos_x[POS_WIDTH-1:0];
            r_pos[4'(r_held) * 4'd3 + 4'd1] <= i_data.pos_y[POS_WIDTH-1:0];
            r_pos[4'(r_held) * 4'd3 + 4'd2] <= i_data.pos_z[POS_WIDTH-1:0];
            r_uv[{r_held, 1'b0}] <= i_data.tex_u;
            r_uv[{r_held, 1'b1}] <= i_data.tex_v;
        end
        if (r_state == S_SETUP) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= (POS_WIDTH+1)'(r_pos[4'(n_b) * 4'd3 + 4'(i)])
                         - (POS_WIDTH+1)'(r_pos[4'(r_k) * 4'd3 + 4'(i)]);
                r_e2[i] <= (POS_WIDTH+1)'(r_pos[4'(n_c) * 4'd3 + 4'(i)])
                         - (POS_WIDTH+1)'(r_pos[4'(r_k) * 4'd3 + 4'(i)]);
            end
            r_d1u <= 17'(r_uv[{n_b, 1'b0}]) - 17'(r_uv[{r_k, 1'b0}]);
            r_d1v <= 17'(r_uv[{n_b, 1'b1}]) - 17'(r_uv[{r_k, 1'b1}]);
            r_d2u <= 17'(r_uv[{n_c, 1'b0}]) - 17'(r_uv[{r_k, 1'b0}]);
            r_d2v <= 17'(r_uv[{n_c, 1'b1}]) - 17'(r_uv[{r_k, 1'b1}]);
            r_vsel <= 1'b0;
        end
        if (r_state == S_PROD) begin
            // Only the sign of det is kept: flip iff det < 0.
            r_flip <= (36'(r_d1u) * 36'(r_d2v)) < (36'(r_d2u) * 36'(r_d1v));
            for (int i = 0; i < 3; i++) begin
                r_tv[i] <= VEC_W'(r_d2v) * VEC_W'(r_e1[i])
                         - VEC_W'(r_d1v) * VEC_W'(r_e2[i]);
                r_bv[i] <= VEC_W'(r_d1u) * VEC_W'(r_e2[i])
                         - VEC_W'(r_d2u) * VEC_W'(r_e1[i]);
            end
        end
        if (r_state == S_VEC) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= n_sh[i][MAG_W-1:0];
                r_neg[i] <= n_v[i][VEC_W-1] != r_flip;
            end
            if (r_vsel) r_zb <= n_zero;
            else        r_zt <= n_zero;
            if (n_zero) begin
                for (int i = 0; i < 3; i++)
                    r_q[3'(r_vsel) * 3'd3 + 3'(i)] <= '0;
            end
        end
        if (r_state == S_DIV && r_wait && !u_busy) begin
            r_q[3'(r_vsel) * 3'd3 + 3'(r_comp)] <=
                (u_quot == 16'd0) ? 16'd0 :
                (r_neg[r_comp] ? 16'(-u_quot) : u_quot);
        end
        if (r_state == S_NEXT) r_vsel <= 1'b1;
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            r_out.corner      <= r_k;
            r_out.tangent_x   <= r_q[0];
            r_out.tangent_y   <= r_q[1];
            r_out.tangent_z   <= r_q[2];
            r_out.bitangent_x <= r_q[3];
            r_out.bitangent_y <= r_q[4];
            r_out.bitangent_z <= r_q[5];
            r_out.zero_length <= r_zt | r_zb;
            r_out.last        <= (r_k == 2'd2);
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.corner == 2'd2)))
        else $error("last does not match corner");
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SQRT) |-> o_stall)
        else $error("input open while unit in use");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("corner count out of range");
endmodule
`default_nettype wire

@@ verif/tb_triangle_tangent_basis.sv @@
module tb_triangle_tangent_basis;
    import ttb_pkg::*;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_RANDOM   = 78;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int HOLD_CYCLES  = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    triangle_tangent_basis DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the corner store.
    longint    held_pos [3][3];
    longint    held_uv  [3][2];
    int        held_cnt = 0;

    t_out_item basis_q [$];
    int        errors = 0;
    int        cycles = 0;
    int        corners_sent = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scales a vector to unit length in Q1.14; returns 1 when it is all zero.
    function automatic bit unit_q14(input longint vx, input longint vy, input longint vz,
                                    input bit flip, output logic signed [15:0] ox,
                                    output logic signed [15:0] oy,
                                    output logic signed [15:0] oz);
        longint          v [3];
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [15:0]     res [3];
        int              s;
        v[0] = vx; v[1] = vy; v[2] = vz;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            ox = 0; oy = 0; oz = 0;
            return 1'b1;
        end
        while ((mx >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= s;
            sum += m[i] * m[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + (len >> 1)) / len;
            res[i] = 16'(((v[i] < 0) != flip) ? -q : q);
        end
        ox = res[0]; oy = res[1]; oz = res[2];
        return 1'b0;
    endfunction

    // Stores one corner; on the third computes the basis of every corner.
    task automatic store_corner(input t_in_item c, output int n, output t_out_item r [3]);
        int     a, b, d;
        longint e1 [3];
        longint e2 [3];
        longint d1u, d1v, d2u, d2v, det;
        bit     flip, zt, zb;
        held_pos[held_cnt][0] = c.pos_x;
        held_pos[held_cnt][1] = c.pos_y;
        held_pos[held_cnt][2] = c.pos_z;
        held_uv[held_cnt][0] = c.tex_u;
        held_uv[held_cnt][1] = c.tex_v;
        if (held_cnt < 2) begin
            held_cnt++;
            n = 0;
            return;
        end
        held_cnt = 0;
        n = 3;
        for (int k = 0; k < 3; k++) begin
            a = k; b = (k + 1) % 3; d = (k + 2) % 3;
            for (int i = 0; i < 3; i++) begin
                e1[i] = held_pos[b][i] - held_pos[a][i];
                e2[i] = held_pos[d][i] - held_pos[a][i];
            end
            d1u = held_uv[b][0] - held_uv[a][0];
            d1v = held_uv[b][1] - held_uv[a][1];
            d2u = held_uv[d][0] - held_uv[a][0];
            d2v = held_uv[d][1] - held_uv[a][1];
            det = d1u * d2v - d2u * d1v;
            flip = det < 0;
            r[k].corner = 2'(k);
            zt = unit_q14(d2v * e1[0] - d1v * e2[0], d2v * e1[1] - d1v * e2[1],
                          d2v * e1[2] - d1v * e2[2], flip,
                          r[k].tangent_x, r[k].tangent_y, r[k].tangent_z);
            zb = unit_q14(d1u * e2[0] - d2u * e1[0], d1u * e2[1] - d2u * e1[1],
                          d1u * e2[2] - d2u * e1[2], flip,
                          r[k].bitangent_x, r[k].bitangent_y, r[k].bitangent_z);
            r[k].zero_length = zt | zb;
            r[k].last = (k == 2);
        end
    endtask

    function automatic t_in_item corner_of(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz, input logic [15:0] u,
                                           input logic [15:0] v);
        t_in_item c;
        c.pos_x = px; c.pos_y = py; c.pos_z = pz; c.tex_u = u; c.tex_v = v;
        return c;
    endfunction

    function automatic logic [31:0] rand_pos(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            default: return 32'($signed($urandom_range(65536)) - 32768);
        endcase
    endfunction

    function automatic logic [15:0] rand_uv(input int kind);
        if (kind == 0) return 16'($urandom);
        return 16'($signed($urandom_range(8192)) - 4096);
    endfunction

    t_in_item dir_tab  [NUM_DIRECTED];
    bit       dir_flat [NUM_DIRECTED];

    initial begin
        // Three identical corners at the top of the position range: both vectors vanish.
        for (int i = 0; i < 3; i++)
            dir_tab[i] = corner_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h8000);
        // Opposite extremes of position and texture coordinate.
        dir_tab[3] = corner_of(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000);
        dir_tab[4] = corner_of(32'h7fffffff, 32'h80000000, 32'h00000000, 16'h7fff, 16'h8000);
        dir_tab[5] = corner_of(32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h7fff);
        // Zero texture determinant: identical UVs.
        dir_tab[6] = corner_of(32'h00000000, 32'h00000000, 32'h00000000, 16'h1000, 16'h1000);
        dir_tab[7] = corner_of(32'h00010000, 32'h00000000, 32'h00000000, 16'h1000, 16'h1000);
        dir_tab[8] = corner_of(32'h00000000, 32'h00010000, 32'h00000000, 16'h1000, 16'h1000);
        // Right triangle with a positive determinant.
        dir_tab[9]  = corner_of(32'h00000000, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000);
        dir_tab[10] = corner_of(32'h00010000, 32'h00000000, 32'h00000000, 16'h1000, 16'h0000);
        dir_tab[11] = corner_of(32'h00000000, 32'h00010000, 32'h00000000, 16'h0000, 16'h1000);
        // Mirrored UVs give a negative determinant.
        dir_tab[12] = corner_of(32'h00000000, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000);
        dir_tab[13] = corner_of(32'h00010000, 32'h00000000, 32'h00000000, 16'hf000, 16'h0000);
        dir_tab[14] = corner_of(32'h00000000, 32'h00010000, 32'h00000000, 16'h0000, 16'h1000);
        // Constant v: the tangent vanishes, the bitangent does not.
        dir_tab[15] = corner_of(32'h00000000, 32'h00000000, 32'h00000000, 16'h0000, 16'h0800);
        dir_tab[16] = corner_of(32'h00020000, 32'hffff0000, 32'h00000000, 16'h1000, 16'h0800);
        dir_tab[17] = corner_of(32'h00000000, 32'h00030000, 32'h00010000, 16'h2000, 16'h0800);
        // Small negative coordinates with mixed signs.
        dir_tab[18] = corner_of(32'hffff8000, 32'h00004000, 32'hfffe0000, 16'hffff, 16'h0001);
        dir_tab[19] = corner_of(32'h00000001, 32'hffffffff, 32'h00000002, 16'h0001, 16'hffff);
        dir_tab[20] = corner_of(32'h00007000, 32'h00001000, 32'hffffd000, 16'h0800, 16'h0800);
        for (int i = 0; i < NUM_DIRECTED; i++) dir_flat[i] = (i == 2);
    end

    task automatic send_corner(input t_in_item c, input bit flat);
        int        n;
        t_out_item r [3];
        t_out_item z;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        store_corner(c, n, r);
        for (int k = 0; k < n; k++) begin
            if (flat) begin
                z = '0;
                z.corner = 2'(k);
                z.zero_length = 1'b1;
                z.last = (k == 2);
                basis_q = {basis_q, z};
            end else begin
                basis_q = {basis_q, r[k]};
            end
        end
        corners_sent++;
    endtask

    initial begin
        t_in_item c;
        t_in_item prev;
        int       pk, uk;
        prev = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < NUM_DIRECTED; i++) send_corner(dir_tab[i], dir_flat[i]);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i < NUM_RANDOM / 3) begin
                send_idle_pct = 16; recv_stall_pct = 55;
            end else if (i < 2 * NUM_RANDOM / 3) begin
                send_idle_pct = 55; recv_stall_pct = 16;
            end else begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            // Mostly proper triangles of moderate size; some full-range and repeated corners.
            pk = $urandom_range(9) < 3 ? 0 : $urandom_range(1, 2);
            uk = $urandom_range(9) < 3 ? 0 : 1;
            c = corner_of(rand_pos(pk), rand_pos(pk), rand_pos(pk), rand_uv(uk), rand_uv(uk));
            if ($urandom_range(19) == 0) c = prev;
            else if ($urandom_range(19) == 0) c.tex_v = prev.tex_v;
            prev = c;
            send_corner(c, 1'b0);
        end
        i_valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Receiver stall, with one long hold-off while corners keep coming.
    always @(posedge i_clk) begin
        if (!hold_done && corners_sent >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (basis_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, got %h", $time, o_data);
            end else begin
                want = basis_q.pop_front();
                check_field("corner", want.corner, o_data.corner);
                check_field("tangent_x", want.tangent_x, o_data.tangent_x);
                check_field("tangent_y", want.tangent_y, o_data.tangent_y);
                check_field("tangent_z", want.tangent_z, o_data.tangent_z);
                check_field("bitangent_x", want.bitangent_x, o_data.bitangent_x);
                check_field("bitangent_y", want.bitangent_y, o_data.bitangent_y);
                check_field("bitangent_z", want.bitangent_z, o_data.bitangent_z);
                check_field("zero_length", want.zero_length, o_data.zero_length);
                check_field("last", want.last, o_data.last);
            end
        end
    end

endmodule

@@ files.f @@
src/ttb_pkg.sv
src/ttb_unit.sv
src/triangle_tangent_basis.sv
verif/tb_triangle_tangent_basis.sv
